// File: rtl/arcpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcpt_pkg
// shared types and codes of the arc progress timing block
// ----------------------------------------------------------------------------
package arcpt_pkg;

    // serial divider geometry
    localparam int DVD_W  = 64;
    localparam int DVS_W  = 29;
    localparam int STEP_W = 7;

    // transaction op codes
    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_COMMIT = 2'd1;
    localparam logic [1:0] OP_START  = 2'd2;

    // motion codes
    localparam logic [1:0] MOT_STILL = 2'd0;
    localparam logic [1:0] MOT_ONCE  = 2'd1;
    localparam logic [1:0] MOT_ROUND = 2'd2;

    // register indexes
    localparam logic [2:0] REG_MOTION      = 3'd0;
    localparam logic [2:0] REG_STILL_SHARE = 3'd1;
    localparam logic [2:0] REG_ZERO_TIME   = 3'd2;
    localparam logic [2:0] REG_TURN_MS     = 3'd3;
    localparam logic [2:0] REG_MIN_STEP    = 3'd4;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DVD_W-1:0]  dividend;
        logic [DVS_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } div_rsp_t;

endpackage

// File: rtl/arcpt_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcpt_div
// restoring divider, one quotient bit per cycle, dividend left aligned
// ----------------------------------------------------------------------------
module arcpt_div (
    input  logic                clk,
    input  logic                rst_n,
    input  arcpt_pkg::div_req_t req,
    output arcpt_pkg::div_rsp_t rsp
);
    import arcpt_pkg::*;

    logic [STEP_W-1:0] cnt_reg;
    logic              done_reg;
    logic [DVD_W-1:0]  num_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  div_reg;

    logic [DVS_W:0]   shifted;
    logic [DVS_W+1:0] trial;
    logic             borrow;

    assign shifted = {rem_reg, num_reg[DVD_W-1]};
    assign trial   = {1'b0, shifted} - {2'b00, div_reg};
    assign borrow  = trial[DVS_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            cnt_reg  <= req.steps;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == STEP_W'(1));
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.dividend;
            rem_reg <= '0;
            div_reg <= req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            num_reg <= {num_reg[DVD_W-2:0], ~borrow};
            rem_reg <= borrow ? shifted[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = num_reg;
    assign rsp.remainder = rem_reg;

endmodule

// File: rtl/arc_progress_timing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_progress_timing
// share of an arc to show at a millisecond tick, and whether a frame is due
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  input     in         in_valid / in_stall       op, now_ms, desk_time
//  output    out        out_valid / out_stall     share, due
//  config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
//  one transaction at a time; a start and a still query skip the divider, as do
//  once at zero or full and a zero turn length; once runs the one-bit-per-cycle
//  divider once, and round runs it twice (turn phase, then share)
//  reset clears state, registers take their reset values, no clearing pass
//  the next transaction is taken while a result waits on a stalled output
// ----------------------------------------------------------------------------
module arc_progress_timing #(
    parameter int TURN_UNITS = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    // apb config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [31:0] now_ms,
    input  logic [63:0] desk_time,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [16:0] share,
    output logic        due
);
    import arcpt_pkg::*;

    // widths that follow from the turn size
    localparam int TU_W  = $clog2(TURN_UNITS + 1);
    localparam int SH_W  = TU_W;
    localparam int W_MAX = (TU_W > 17) ? TU_W : 17;
    localparam int NUM_W = 28 + TU_W;
    localparam logic [TU_W-1:0] TU = TU_W'(TURN_UNITS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TIME,
        S_DIFF,
        S_MAG,
        S_SEL,
        S_WMOD,
        S_MUL,
        S_DIVQ,
        S_WQ,
        S_DUE1,
        S_DUE2,
        S_DONE
    } state_t;

    // configuration registers
    logic [1:0]  motion_reg;
    logic [16:0] still_share_reg;
    logic [63:0] zero_time_reg;
    logic [27:0] turn_ms_reg;
    logic [16:0] min_step_reg;

    // timing state
    logic [63:0]     desk_clock_reg;
    logic [31:0]     last_ms_reg;
    logic [SH_W-1:0] shown_share_reg;
    logic            shown_valid_reg;

    // sequencer and working registers
    state_t          state_reg;
    logic [1:0]      op_reg;
    logic [31:0]     now_reg;
    logic [63:0]     desk_in_reg;
    logic [63:0]     at_reg;
    logic [63:0]     diff_reg;
    logic [63:0]     mag_reg;
    logic            neg_reg;
    logic [27:0]     d_reg;
    logic            dneg_reg;
    logic [27:0]     opnd_reg;
    logic [NUM_W-1:0] prod_reg;
    logic [SH_W-1:0] share_reg;
    logic [SH_W-1:0] moved_reg;
    logic            eq_reg;
    logic            force_reg;
    logic            due_reg;
    logic            out_valid_reg;
    logic [16:0]     out_share_reg;
    logic            out_due_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // --------------------------------------------------------------------
    // config port
    // --------------------------------------------------------------------
    logic       cfg_write;
    logic [2:0] cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_idx   = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_reg      <= MOT_STILL;
            still_share_reg <= '0;
            zero_time_reg   <= '0;
            turn_ms_reg     <= 28'd1000;
            min_step_reg    <= 17'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_MOTION:      motion_reg      <= pwdata[1:0];
                REG_STILL_SHARE: still_share_reg <= pwdata[16:0];
                REG_ZERO_TIME:   zero_time_reg   <= pwdata;
                REG_TURN_MS:     turn_ms_reg     <= pwdata[27:0];
                REG_MIN_STEP:    min_step_reg    <= pwdata[16:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_MOTION:      prdata = 64'(motion_reg);
            REG_STILL_SHARE: prdata = 64'(still_share_reg);
            REG_ZERO_TIME:   prdata = zero_time_reg;
            REG_TURN_MS:     prdata = 64'(turn_ms_reg);
            REG_MIN_STEP:    prdata = 64'(min_step_reg);
            default:         prdata = '0;
        endcase
    end

    // --------------------------------------------------------------------
    // shared divider
    // --------------------------------------------------------------------
    arcpt_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // --------------------------------------------------------------------
    // datapath terms
    // --------------------------------------------------------------------
    logic [31:0]      elapsed;
    logic [27:0]      d_abs;
    logic [W_MAX-1:0] still_ext;
    logic [SH_W-1:0]  still_sat;
    logic [NUM_W-1:0] prod_comb;
    logic [NUM_W-1:0] num_once;
    logic [NUM_W-1:0] q_low;
    logic [27:0]      rem_low;
    logic [SH_W-1:0]  other;
    logic [SH_W-1:0]  least;
    logic             wrap_back;

    assign elapsed   = now_reg - last_ms_reg;
    assign d_abs     = turn_ms_reg[27] ? (~turn_ms_reg + 28'd1) : turn_ms_reg;
    assign still_ext = W_MAX'(still_share_reg);
    assign still_sat = (still_ext > W_MAX'(TU)) ? SH_W'(TU) : SH_W'(still_share_reg);
    assign prod_comb = NUM_W'(opnd_reg) * NUM_W'(TU);
    assign num_once  = (prod_reg << 1) + NUM_W'(d_reg);
    assign q_low     = div_rsp.quotient[NUM_W-1:0];
    assign rem_low   = div_rsp.remainder[27:0];
    assign wrap_back = (neg_reg != dneg_reg);
    // moved never exceeds a full turn, so this cannot underflow
    assign other     = SH_W'(TU) - moved_reg;
    assign least     = (other < moved_reg) ? other : moved_reg;

    always_comb
    begin
        div_req          = '0;
        div_req.steps    = STEP_W'(DVD_W);
        div_req.dividend = mag_reg;
        div_req.divisor  = DVS_W'(d_reg);
        if (state_reg == S_SEL && motion_reg == MOT_ROUND && d_reg != '0
            && op_reg != OP_START)
        begin
            div_req.start = 1'b1;
        end
        else if (state_reg == S_DIVQ)
        begin
            div_req.start = 1'b1;
            div_req.steps = STEP_W'(NUM_W);
            if (motion_reg == MOT_ONCE)
            begin
                // round to nearest: (2*mag*units + d) / (2*d)
                div_req.dividend = DVD_W'(num_once) << (DVD_W - NUM_W);
                div_req.divisor  = {d_reg, 1'b0};
            end
            else
            begin
                div_req.dividend = DVD_W'(prod_reg) << (DVD_W - NUM_W);
            end
        end
    end

    // --------------------------------------------------------------------
    // sequencer
    // --------------------------------------------------------------------
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign share     = out_share_reg;
    assign due       = out_due_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            out_valid_reg   <= 1'b0;
            desk_clock_reg  <= '0;
            last_ms_reg     <= '0;
            shown_share_reg <= '0;
            shown_valid_reg <= 1'b0;
        end
        else
        begin
            // in the hand-over state the output register is loaded below instead
            if (out_valid_reg && !out_stall && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg      <= op;
                        now_reg     <= now_ms;
                        desk_in_reg <= desk_time;
                        state_reg   <= S_TIME;
                    end
                end

                S_TIME:
                begin
                    // desktop time now, the tick delta wraps at 32 bits
                    at_reg    <= desk_clock_reg + 64'(elapsed);
                    state_reg <= S_DIFF;
                end

                S_DIFF:
                begin
                    diff_reg  <= at_reg - zero_time_reg;
                    d_reg     <= d_abs;
                    dneg_reg  <= turn_ms_reg[27];
                    state_reg <= S_MAG;
                end

                S_MAG:
                begin
                    neg_reg   <= diff_reg[63];
                    mag_reg   <= diff_reg[63] ? (~diff_reg + 64'd1) : diff_reg;
                    state_reg <= S_SEL;
                end

                S_SEL:
                begin
                    state_reg <= S_DUE1;
                    if (op_reg == OP_START)
                    begin
                        desk_clock_reg  <= desk_in_reg;
                        last_ms_reg     <= now_reg;
                        shown_valid_reg <= 1'b0;
                        share_reg       <= '0;
                        due_reg         <= 1'b0;
                        state_reg       <= S_DONE;
                    end
                    else if (motion_reg != MOT_ONCE && motion_reg != MOT_ROUND)
                    begin
                        share_reg <= still_sat;
                    end
                    else if (d_reg == '0)
                    begin
                        share_reg <= '0;
                    end
                    else if (motion_reg == MOT_ONCE)
                    begin
                        if (mag_reg == '0 || wrap_back)
                        begin
                            share_reg <= '0;
                        end
                        else if (mag_reg >= 64'(d_reg))
                        begin
                            share_reg <= SH_W'(TU);
                        end
                        else
                        begin
                            opnd_reg  <= mag_reg[27:0];
                            state_reg <= S_MUL;
                        end
                    end
                    else
                    begin
                        // position within the turn comes from mag mod d
                        state_reg <= S_WMOD;
                    end
                end

                S_WMOD:
                begin
                    if (div_rsp.done)
                    begin
                        // running against the turn direction mirrors the phase
                        if (wrap_back && rem_low != '0)
                        begin
                            opnd_reg <= d_reg - rem_low;
                        end
                        else
                        begin
                            opnd_reg <= rem_low;
                        end
                        state_reg <= S_MUL;
                    end
                end

                S_MUL:
                begin
                    prod_reg  <= prod_comb;
                    state_reg <= S_DIVQ;
                end

                S_DIVQ:
                begin
                    state_reg <= S_WQ;
                end

                S_WQ:
                begin
                    if (div_rsp.done)
                    begin
                        if (motion_reg == MOT_ROUND && q_low > NUM_W'(TU - TU_W'(1)))
                        begin
                            share_reg <= SH_W'(TU - TU_W'(1));
                        end
                        else
                        begin
                            share_reg <= SH_W'(q_low);
                        end
                        state_reg <= S_DUE1;
                    end
                end

                S_DUE1:
                begin
                    eq_reg    <= shown_valid_reg && (share_reg == shown_share_reg);
                    force_reg <= !shown_valid_reg || (share_reg == '0)
                                 || (share_reg >= SH_W'(TU));
                    moved_reg <= (share_reg > shown_share_reg)
                                 ? (share_reg - shown_share_reg)
                                 : (shown_share_reg - share_reg);
                    state_reg <= S_DUE2;
                end

                S_DUE2:
                begin
                    // short way round against the least step
                    if (eq_reg)
                    begin
                        due_reg <= 1'b0;
                    end
                    else if (force_reg)
                    begin
                        due_reg <= 1'b1;
                    end
                    else
                    begin
                        due_reg <= (W_MAX'(least) >= W_MAX'(min_step_reg));
                    end
                    if (op_reg == OP_COMMIT)
                    begin
                        desk_clock_reg  <= at_reg;
                        last_ms_reg     <= now_reg;
                        shown_share_reg <= share_reg;
                        shown_valid_reg <= 1'b1;
                    end
                    state_reg <= S_DONE;
                end

                S_DONE:
                begin
                    // hand over once the output register is free
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_share_reg <= 17'(share_reg);
                        out_due_reg   <= due_reg;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
